// File: src/ecr_pkg.sv
package ecr_pkg;

    localparam int CHAN_W   = 8;
    localparam int CHANNELS = 3;
    localparam int OUT_W    = 32;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 8;
    localparam int INDEX_W  = 3;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [CHANNELS-1:0] rgb_t;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IW-1:0]
    {
        REG_ENTRY_COUNT = 2'd0,
        REG_LINEAR_MODE = 2'd1,
        REG_ALPHA_LEVEL = 2'd2
    } cfg_reg_t;

    typedef struct packed
    {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

// File: src/ecr_select.sv
module ecr_select #(
    parameter int MAX_ENTRIES = 8,
    parameter int HEIGHT_BITS = 16,
    localparam int IW = $clog2(MAX_ENTRIES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ecr_pkg::stage_ctl_t           ctl_in,
    input  logic signed [HEIGHT_BITS-1:0] height,
    input  logic signed [HEIGHT_BITS-1:0] thr [MAX_ENTRIES],
    input  ecr_pkg::rgb_t                 col [MAX_ENTRIES],
    input  logic [3:0]                    entry_count,
    input  logic                          linear_mode,
    output logic                          valid_out,
    output logic                          direct_out,
    output logic signed [HEIGHT_BITS-1:0] h_out,
    output logic signed [HEIGHT_BITS-1:0] ta_out,
    output logic signed [HEIGHT_BITS-1:0] tb_out,
    output ecr_pkg::rgb_t                 ca_out,
    output ecr_pkg::rgb_t                 cb_out
);

    logic [IW:0]   n_eff;
    logic          found;
    logic [IW-1:0] idx;
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
    logic          direct;

    logic                          valid_reg;
    logic                          direct_reg;
    logic signed [HEIGHT_BITS-1:0] h_reg;
    logic signed [HEIGHT_BITS-1:0] ta_reg;
    logic signed [HEIGHT_BITS-1:0] tb_reg;
    ecr_pkg::rgb_t                 ca_reg;
    ecr_pkg::rgb_t                 cb_reg;

    always_comb
    begin
        if (entry_count == 4'd0)
        begin
            n_eff = (IW+1)'(1);
        end
        else if (32'(entry_count) > MAX_ENTRIES)
        begin
            n_eff = (IW+1)'(MAX_ENTRIES);
        end
        else
        begin
            n_eff = (IW+1)'(entry_count);
        end

        found = 1'b0;
        idx   = '0;
        for (int j = MAX_ENTRIES - 1; j >= 0; j--)
        begin
            if (((IW+1)'(j) < n_eff) && (height <= thr[j]))
            begin
                found = 1'b1;
                idx   = IW'(j);
            end
        end

        if (!found)
        begin
            lo = IW'(n_eff - (IW+1)'(1));
        end
        else if (idx == '0)
        begin
            lo = '0;
        end
        else
        begin
            lo = idx - IW'(1);
        end
        hi     = found ? idx : lo;
        direct = !found || (idx == '0) || !linear_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.en)
        begin
            direct_reg <= direct;
            h_reg      <= height;
            ta_reg     <= thr[lo];
            tb_reg     <= thr[hi];
            ca_reg     <= col[lo];
            cb_reg     <= col[hi];
        end
    end

    assign valid_out  = valid_reg;
    assign direct_out = direct_reg;
    assign h_out      = h_reg;
    assign ta_out     = ta_reg;
    assign tb_out     = tb_reg;
    assign ca_out     = ca_reg;
    assign cb_out     = cb_reg;

endmodule

// File: src/ecr_mix.sv
module ecr_mix #(
    parameter int HEIGHT_BITS = 16,
    localparam int DW = HEIGHT_BITS + 1,
    localparam int NW = DW + ecr_pkg::CHAN_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ecr_pkg::stage_ctl_t           ctl_in,
    input  logic                          direct,
    input  logic signed [HEIGHT_BITS-1:0] h,
    input  logic signed [HEIGHT_BITS-1:0] ta,
    input  logic signed [HEIGHT_BITS-1:0] tb,
    input  ecr_pkg::rgb_t                 ca,
    input  ecr_pkg::rgb_t                 cb,
    output logic                          span_valid,
    output logic [DW-1:0]                 span_d,
    output logic [DW-1:0]                 span_e,
    output logic                          valid_out,
    output logic [DW-1:0]                 d_out,
    output logic [NW-1:0]                 num_out [ecr_pkg::CHANNELS]
);

    logic signed [DW-1:0] d_full;
    logic signed [DW-1:0] e_full;
    logic [NW-1:0]        num [ecr_pkg::CHANNELS];

    logic          c_valid_reg;
    logic [DW-1:0] c_d_reg;
    logic [DW-1:0] c_e_reg;
    logic [DW-1:0] c_dm_reg;
    ecr_pkg::rgb_t c_ca_reg;
    ecr_pkg::rgb_t c_cb_reg;

    logic          m_valid_reg;
    logic [DW-1:0] m_d_reg;
    logic [NW-1:0] m_num_reg [ecr_pkg::CHANNELS];

    always_comb
    begin
        if (direct)
        begin
            d_full = DW'(1);
            e_full = '0;
        end
        else
        begin
            d_full = DW'(tb) - DW'(ta);
            e_full = DW'(h) - DW'(ta);
        end
    end

    always_comb
    begin
        for (int c = 0; c < ecr_pkg::CHANNELS; c++)
        begin
            num[c] = NW'(c_ca_reg[c]) * NW'(c_dm_reg) + NW'(c_cb_reg[c]) * NW'(c_e_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (ctl_in.en)
        begin
            c_valid_reg <= ctl_in.valid;
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.en)
        begin
            c_d_reg  <= d_full;
            c_e_reg  <= e_full;
            c_dm_reg <= d_full - e_full;
            c_ca_reg <= ca;
            c_cb_reg <= cb;
            m_d_reg  <= c_d_reg;
            m_num_reg <= num;
        end
    end

    assign span_valid = c_valid_reg;
    assign span_d     = c_d_reg;
    assign span_e     = c_e_reg;
    assign valid_out  = m_valid_reg;
    assign d_out      = m_d_reg;
    assign num_out    = m_num_reg;

endmodule

// File: src/ecr_div_stage.sv
module ecr_div_stage #(
    parameter int DW = 17,
    parameter int TOP_BIT = 7,
    localparam int NW = DW + ecr_pkg::CHAN_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ecr_pkg::stage_ctl_t   ctl_in,
    input  logic [DW-1:0]         d_in,
    input  logic [NW-1:0]         r_in [ecr_pkg::CHANNELS],
    input  ecr_pkg::rgb_t         q_in,
    output logic                  valid_out,
    output logic [DW-1:0]         d_out,
    output logic [NW-1:0]         r_out [ecr_pkg::CHANNELS],
    output ecr_pkg::rgb_t         q_out
);

    logic [NW-1:0]  r_next [ecr_pkg::CHANNELS];
    ecr_pkg::rgb_t  q_next;
    logic [NW-1:0]  ds;

    logic           valid_reg;
    logic [DW-1:0]  d_reg;
    logic [NW-1:0]  r_reg [ecr_pkg::CHANNELS];
    ecr_pkg::rgb_t  q_reg;

    always_comb
    begin
        r_next = r_in;
        q_next = q_in;
        ds     = '0;
        for (int b = TOP_BIT; b > TOP_BIT - 2; b--)
        begin
            ds = NW'(d_in) << b;
            for (int c = 0; c < ecr_pkg::CHANNELS; c++)
            begin
                if (r_next[c] >= ds)
                begin
                    r_next[c]    = r_next[c] - ds;
                    q_next[c][b] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.en)
        begin
            d_reg <= d_in;
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;
    assign r_out     = r_reg;
    assign q_out     = q_reg;

endmodule

// File: src/elevation_colour_ramp_core.sv
// Height-to-RGBA color ramp.
// Input beats on s_axis: tuser is the opcode (0 load a ramp entry, 1 color a
// height sample). A load writes its threshold and color into the table at the
// accepting edge and gives no output beat; a sample gives one output beat.
// Load all entries a sample uses before sending it; config (cfg_we, cfg_index,
// cfg_data) must be written only while the pipeline is empty (not enforced).
// Output beats on m_axis carry red, green, blue, alpha from the lowest byte.
// A sample beat accepted on s_axis passes through the input register, table
// search, span, products and four divider stages of two quotient bits each
// before it appears on m_axis. One beat per cycle while m_axis is not stalled.
// The whole pipeline advances together; when the receiver holds m_axis_tready
// low with a beat pending, every stage holds and s_axis_tready drops.
// Reset clears all valid bits and sets entry_count 1, linear mode, alpha 255;
// the ramp table is not cleared.
module elevation_colour_ramp_core #(
    parameter int MAX_ENTRIES = 8,
    parameter int HEIGHT_BITS = 16,
    localparam int IN_BITS = ecr_pkg::INDEX_W + 2 * HEIGHT_BITS + 3 * ecr_pkg::CHAN_W,
    localparam int IN_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // entry_index, entry_threshold, entry_red, entry_green, entry_blue, height
    input  logic [IN_W-1:0]               s_axis_tdata,
    // opcode
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_red, pixel_green, pixel_blue, pixel_alpha
    output logic [ecr_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [ecr_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [ecr_pkg::CFG_DW-1:0]    cfg_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int DW = HEIGHT_BITS + 1;
    localparam int NW = DW + ecr_pkg::CHAN_W;
    localparam int DIV_STAGES = 4;
    localparam int CW = ecr_pkg::CHAN_W;
    localparam int TH_LO = ecr_pkg::INDEX_W;
    localparam int RED_LO = TH_LO + HEIGHT_BITS;
    localparam int GRN_LO = RED_LO + CW;
    localparam int BLU_LO = GRN_LO + CW;
    localparam int HGT_LO = BLU_LO + CW;

    logic [3:0] entry_count_reg;
    logic       linear_mode_reg;
    logic [7:0] alpha_level_reg;

    logic signed [HEIGHT_BITS-1:0] thr_reg [MAX_ENTRIES];
    ecr_pkg::rgb_t                 col_reg [MAX_ENTRIES];

    logic                          advance;
    logic                          in_fire;
    logic [ecr_pkg::INDEX_W-1:0]   in_index;
    logic [IW+ecr_pkg::INDEX_W-1:0] in_index_ext;
    ecr_pkg::rgb_t                 in_rgb;

    logic                          a_valid_reg;
    logic signed [HEIGHT_BITS-1:0] a_height_reg;

    ecr_pkg::stage_ctl_t ctl_a;
    ecr_pkg::stage_ctl_t ctl_b;
    ecr_pkg::stage_ctl_t ctl_div [DIV_STAGES];

    logic                          b_valid;
    logic                          b_direct;
    logic signed [HEIGHT_BITS-1:0] b_h;
    logic signed [HEIGHT_BITS-1:0] b_ta;
    logic signed [HEIGHT_BITS-1:0] b_tb;
    ecr_pkg::rgb_t                 b_ca;
    ecr_pkg::rgb_t                 b_cb;

    logic          span_valid;
    logic [DW-1:0] span_d;
    logic [DW-1:0] span_e;
    logic          mix_valid;
    logic [DW-1:0] mix_d;
    logic [NW-1:0] mix_num [ecr_pkg::CHANNELS];

    logic          dv_valid [DIV_STAGES+1];
    logic [DW-1:0] dv_d     [DIV_STAGES+1];
    logic [NW-1:0] dv_r     [DIV_STAGES+1][ecr_pkg::CHANNELS];
    ecr_pkg::rgb_t dv_q     [DIV_STAGES+1];

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_index      = s_axis_tdata[ecr_pkg::INDEX_W-1:0];
    assign in_index_ext  = (IW+ecr_pkg::INDEX_W)'(in_index);
    assign in_rgb        = {s_axis_tdata[BLU_LO +: CW], s_axis_tdata[GRN_LO +: CW],
                            s_axis_tdata[RED_LO +: CW]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 4'd1;
            linear_mode_reg <= 1'b1;
            alpha_level_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ecr_pkg::REG_ENTRY_COUNT: entry_count_reg <= cfg_data[3:0];
                ecr_pkg::REG_LINEAR_MODE: linear_mode_reg <= cfg_data[0];
                ecr_pkg::REG_ALPHA_LEVEL: alpha_level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (s_axis_tuser == ecr_pkg::OP_LOAD)
            && (32'(in_index) < MAX_ENTRIES))
        begin
            thr_reg[in_index_ext[IW-1:0]] <= s_axis_tdata[TH_LO +: HEIGHT_BITS];
            col_reg[in_index_ext[IW-1:0]] <= in_rgb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_fire && (s_axis_tuser == ecr_pkg::OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_height_reg <= s_axis_tdata[HGT_LO +: HEIGHT_BITS];
        end
    end

    assign ctl_a = '{en: advance, valid: a_valid_reg};
    assign ctl_b = '{en: advance, valid: b_valid};

    ecr_select #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (ctl_a),
        .height     (a_height_reg),
        .thr        (thr_reg),
        .col        (col_reg),
        .entry_count(entry_count_reg),
        .linear_mode(linear_mode_reg),
        .valid_out  (b_valid),
        .direct_out (b_direct),
        .h_out      (b_h),
        .ta_out     (b_ta),
        .tb_out     (b_tb),
        .ca_out     (b_ca),
        .cb_out     (b_cb)
    );

    ecr_mix #(
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl_b),
        .direct    (b_direct),
        .h         (b_h),
        .ta        (b_ta),
        .tb        (b_tb),
        .ca        (b_ca),
        .cb        (b_cb),
        .span_valid(span_valid),
        .span_d    (span_d),
        .span_e    (span_e),
        .valid_out (mix_valid),
        .d_out     (mix_d),
        .num_out   (mix_num)
    );

    assign dv_valid[0] = mix_valid;
    assign dv_d[0]     = mix_d;
    assign dv_r[0]     = mix_num;
    assign dv_q[0]     = '0;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        assign ctl_div[k] = '{en: advance, valid: dv_valid[k]};

        ecr_div_stage #(
            .DW     (DW),
            .TOP_BIT(CW - 1 - 2 * k)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (ctl_div[k]),
            .d_in     (dv_d[k]),
            .r_in     (dv_r[k]),
            .q_in     (dv_q[k]),
            .valid_out(dv_valid[k+1]),
            .d_out    (dv_d[k+1]),
            .r_out    (dv_r[k+1]),
            .q_out    (dv_q[k+1])
        );
    end

    assign m_axis_tvalid = dv_valid[DIV_STAGES];
    assign m_axis_tdata  = {alpha_level_reg, dv_q[DIV_STAGES][2], dv_q[DIV_STAGES][1],
                            dv_q[DIV_STAGES][0]};

    a_span_positive: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> (span_d != '0) && (span_e <= span_d))
        else $error("interpolation span out of range");

    a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (dv_r[DIV_STAGES][0] < NW'(dv_d[DIV_STAGES]))
                       && (dv_r[DIV_STAGES][1] < NW'(dv_d[DIV_STAGES]))
                       && (dv_r[DIV_STAGES][2] < NW'(dv_d[DIV_STAGES])))
        else $error("divider remainder not reduced");

    a_load_makes_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_axis_tuser == ecr_pkg::OP_LOAD)) |=> !a_valid_reg)
        else $error("load beat entered the pixel pipeline");

endmodule

// File: tb/elevation_colour_ramp_core_test.sv
`timescale 1ns / 100ps

module elevation_colour_ramp_core_test;

    localparam int IN_W = 64;
    localparam int LATENCY = 8;
    localparam int FIFO_DEPTH = 4096;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [ecr_pkg::OUT_W-1:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [ecr_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [ecr_pkg::CFG_DW-1:0] cfg_data = '0;

    logic signed [15:0] ramp_threshold [8];
    logic [23:0] ramp_colour [8];
    logic [3:0] entry_count_q = 4'd1;
    logic linear_q = 1'b1;
    logic [7:0] alpha_q = 8'd255;

    pixel_t want_fifo [FIFO_DEPTH];
    int wr_count = 0;
    int rd_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    longint cycle_count = 0;

    elevation_colour_ramp_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL elevation_colour_ramp_core");
            $finish;
        end
    end

    function automatic pixel_t ramp_pixel(logic signed [15:0] h);
        int n;
        int k;
        int d;
        int e;
        int c1;
        int c2;
        logic [23:0] rgb;
        pixel_t p;
        n = (entry_count_q == 0) ? 1 : (entry_count_q > 8 ? 8 : entry_count_q);
        k = n;
        for (int j = n - 1; j >= 0; j--)
            if (h <= ramp_threshold[j])
                k = j;
        if (k == n)
            rgb = ramp_colour[n-1];
        else if (k == 0)
            rgb = ramp_colour[0];
        else if (!linear_q)
            rgb = ramp_colour[k-1];
        else
        begin
            d = int'(ramp_threshold[k]) - int'(ramp_threshold[k-1]);
            e = int'(h) - int'(ramp_threshold[k-1]);
            for (int s = 0; s < 24; s += 8)
            begin
                c1 = (ramp_colour[k-1] >> s) & 8'hFF;
                c2 = (ramp_colour[k] >> s) & 8'hFF;
                rgb[s +: 8] = 8'((longint'(c1) * (d - e) + longint'(c2) * e) / d);
            end
        end
        p.red = rgb[23:16];
        p.green = rgb[15:8];
        p.blue = rgb[7:0];
        p.alpha = alpha_q;
        return p;
    endfunction

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tdata[31:24]};
            if (rd_count == wr_count)
            begin
                $display("%0t unexpected pixel: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = want_fifo[rd_count];
                rd_count++;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha)
                begin
                    $display("%0t pixel mismatch: expected %h, actual %h", $time, want, got);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_beat(bit op, logic [2:0] idx, logic [15:0] thr,
                             logic [23:0] rgb, logic [15:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {5'b0, h, rgb[7:0], rgb[15:8], rgb[23:16], thr, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == ecr_pkg::OP_LOAD)
        begin
            ramp_threshold[idx] = thr;
            ramp_colour[idx] = rgb;
        end
        else if (wr_count < FIFO_DEPTH)
        begin
            want_fifo[wr_count] = ramp_pixel(h);
            wr_count++;
        end
    endtask

    task automatic load_entry(int idx, logic [15:0] thr, logic [23:0] rgb);
        send_beat(ecr_pkg::OP_LOAD, idx[2:0], thr, rgb, 16'($urandom));
    endtask

    task automatic sample(logic [15:0] h);
        send_beat(ecr_pkg::OP_SAMPLE, 3'($urandom), 16'($urandom), 24'($urandom), h);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (rd_count != wr_count && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(ecr_pkg::cfg_reg_t r, logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (r)
            ecr_pkg::REG_ENTRY_COUNT: entry_count_q = v[3:0];
            ecr_pkg::REG_LINEAR_MODE: linear_q = v[0];
            ecr_pkg::REG_ALPHA_LEVEL: alpha_q = v;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_height();
        int idx;
        idx = $urandom_range(7);
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return ramp_threshold[idx];
            2: return ramp_threshold[idx] + 16'sd1;
            3: return 16'h8000;
            4: return 16'h7FFF;
            default: return ramp_threshold[idx] + 16'($urandom_range(40)) - 16'sd20;
        endcase
    endfunction

    task automatic load_sorted_ramp(bit wide);
        int t;
        t = wide ? -32768 : -200 + $urandom_range(100);
        for (int j = 0; j < 8; j++)
        begin
            load_entry(j, 16'(t), 24'($urandom));
            t += wide ? $urandom_range(9362) : $urandom_range(60);
            if (t > 32767)
                t = 32767;
        end
    endtask

    task automatic test_directed();
        load_entry(0, 16'h8000, 24'h000000);
        load_entry(1, 16'hFF00, 24'hFFFFFF);
        load_entry(2, 16'h0000, 24'h00FF00);
        load_entry(3, 16'h0100, 24'hFF00FF);
        load_entry(4, 16'h7FFF, 24'h123456);
        load_entry(5, 16'h0080, 24'hABCDEF);
        load_entry(6, 16'h0010, 24'h0F0F0F);
        load_entry(7, 16'h7FFF, 24'hF0F0F0);
        write_reg(ecr_pkg::REG_ENTRY_COUNT, 8'd8);
        sample(16'h8000);
        sample(16'h8001);
        sample(16'hFF00);
        sample(16'hFFFF);
        sample(16'h0000);
        sample(16'h0080);
        sample(16'h7FFF);
        sample(16'h5555);
        sample(16'hAAAA);
        drain();
        write_reg(ecr_pkg::REG_LINEAR_MODE, 8'd0);
        write_reg(ecr_pkg::REG_ALPHA_LEVEL, 8'd0);
        sample(16'h8001);
        sample(16'h00F0);
        sample(16'h7FFF);
        drain();
        write_reg(ecr_pkg::REG_ENTRY_COUNT, 8'd1);
        sample(16'h7FFF);
        sample(16'h8000);
        drain();
        write_reg(ecr_pkg::REG_ENTRY_COUNT, 8'd3);
        write_reg(ecr_pkg::REG_LINEAR_MODE, 8'd1);
        write_reg(ecr_pkg::REG_ALPHA_LEVEL, 8'd255);
        sample(16'h7FFF);
        sample(16'hFF80);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        send_idle_pct = idle;
        stall_pct = stall;
        write_reg(ecr_pkg::REG_ENTRY_COUNT, 8'($urandom_range(15)));
        write_reg(ecr_pkg::REG_LINEAR_MODE, 8'($urandom_range(1)));
        write_reg(ecr_pkg::REG_ALPHA_LEVEL, 8'($urandom));
        load_sorted_ramp($urandom_range(1));
        for (int j = 0; j < count; j++)
        begin
            if ($urandom_range(19) == 0)
                load_entry($urandom_range(7), 16'($urandom), 24'($urandom));
            else
                sample(pick_height());
        end
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 0, 200);
        test_random_phase(65, 0, 200);
        test_random_phase(0, 65, 200);
        test_random_phase(34, 34, 200);
        test_random_phase(0, 0, 200);
        if (errors == 0 && rd_count == wr_count)
            $display("PASS elevation_colour_ramp_core");
        else
            $display("FAIL elevation_colour_ramp_core");
        $finish;
    end
endmodule
